/* hdl/mbd_pkg.sv */
// ----------------------------------------------------------------------------
// Mipmap box downsampler package
// Shared widths, pixel and result types for the downsampler cells and queue.
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int MAX_SIDE_LOG2_DEFAULT = 10;
   localparam int CFG_W   = 4;
   localparam int LEVEL_W = 4;
   localparam int POS_W   = 10;
   localparam int IN_W    = 8;
   localparam int CHAN_W  = 16;
   localparam int SUM_W   = CHAN_W + 1;
   localparam int ACC_W   = CHAN_W + 2;
   localparam int FRAC_W  = 8;
   localparam logic [CFG_W-1:0] SIDE_LOG2_RESET = CFG_W'(10);

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } pair_sum_type;

   typedef struct packed {
      logic valid;
      logic last;
   } cell_flags_type;

   typedef struct packed {
      logic               last;
      pixel_type          pix;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_x;
      logic [LEVEL_W-1:0] level;
   } result_type;

endpackage

/* hdl/mbd_cell.sv */
// ----------------------------------------------------------------------------
// Mipmap box downsampler level cell
// Holds the pending left pixel and the pair-sum line of one level, reports
// the pixel it holds and hands the completed coarser pixel to its neighbor.
// ----------------------------------------------------------------------------
module mbd_cell #(
   parameter int MaxLog2 = mbd_pkg::MAX_SIDE_LOG2_DEFAULT,
   parameter int Level   = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [mbd_pkg::CFG_W-1:0]  side_log2,
   input  logic                       in_valid,
   input  logic [MaxLog2-1:0]         in_x,
   input  logic [MaxLog2-1:0]         in_y,
   input  mbd_pkg::pixel_type         in_pix,
   output mbd_pkg::cell_flags_type    res_flags,
   output logic [MaxLog2-1:0]         res_x,
   output logic [MaxLog2-1:0]         res_y,
   output mbd_pkg::pixel_type         res_pix,
   output logic                       next_valid,
   output logic [MaxLog2-1:0]         next_x,
   output logic [MaxLog2-1:0]         next_y,
   output mbd_pkg::pixel_type         next_pix
);

   logic                valid_ff;
   logic [MaxLog2-1:0]  x_ff;
   logic [MaxLog2-1:0]  y_ff;
   mbd_pkg::pixel_type  pix_ff;
   logic                last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         x_ff   <= in_x;
         y_ff   <= in_y;
         pix_ff <= in_pix;
      end
   end

   assign last = (mbd_pkg::CFG_W'(Level) >= side_log2) || !(x_ff[0] && y_ff[0]);

   assign res_flags.valid = valid_ff;
   assign res_flags.last  = last;
   assign res_x           = x_ff;
   assign res_y           = y_ff;
   assign res_pix         = pix_ff;

   generate
      if (Level < MaxLog2) begin : g_proc
         localparam int AW = (MaxLog2 - 1 - Level >= 1) ? (MaxLog2 - 1 - Level) : 1;

         mbd_pkg::pair_sum_type line_mem [2**AW];
         mbd_pkg::pair_sum_type rd_ff;
         mbd_pkg::pixel_type    pending_ff;
         mbd_pkg::pair_sum_type h;
         mbd_pkg::pixel_type    avg;
         logic                  proc_en;

         assign proc_en = valid_ff && (mbd_pkg::CFG_W'(Level) < side_log2);

         assign h.red   = mbd_pkg::SUM_W'(pending_ff.red)   + mbd_pkg::SUM_W'(pix_ff.red);
         assign h.green = mbd_pkg::SUM_W'(pending_ff.green) + mbd_pkg::SUM_W'(pix_ff.green);
         assign h.blue  = mbd_pkg::SUM_W'(pending_ff.blue)  + mbd_pkg::SUM_W'(pix_ff.blue);

         assign avg.red   = mbd_pkg::CHAN_W'((mbd_pkg::ACC_W'(rd_ff.red)
                                              + mbd_pkg::ACC_W'(h.red)) >> 2);
         assign avg.green = mbd_pkg::CHAN_W'((mbd_pkg::ACC_W'(rd_ff.green)
                                              + mbd_pkg::ACC_W'(h.green)) >> 2);
         assign avg.blue  = mbd_pkg::CHAN_W'((mbd_pkg::ACC_W'(rd_ff.blue)
                                              + mbd_pkg::ACC_W'(h.blue)) >> 2);

         always_ff @(posedge clock) begin
            rd_ff <= line_mem[AW'(in_x >> 1)];
            if (proc_en && x_ff[0] && !y_ff[0]) begin
               line_mem[AW'(x_ff >> 1)] <= h;
            end
         end

         always_ff @(posedge clock) begin
            if (proc_en && !x_ff[0]) begin
               pending_ff <= pix_ff;
            end
         end

         assign next_valid = valid_ff && !last;
         assign next_x     = x_ff >> 1;
         assign next_y     = y_ff >> 1;
         assign next_pix   = avg;
      end else begin : g_end
         assign next_valid = 1'b0;
         assign next_x     = '0;
         assign next_y     = '0;
         assign next_pix   = '0;
      end
   endgenerate

endmodule

/* hdl/mbd_fifo.sv */
// ----------------------------------------------------------------------------
// Mipmap box downsampler result queue
// Small register queue that absorbs the burst of level results of one item.
// ----------------------------------------------------------------------------
module mbd_fifo #(
   parameter int DepthLog2 = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbd_pkg::result_type  push_data,
   input  logic                 pop,
   output logic                 out_valid,
   output mbd_pkg::result_type  out_data,
   output logic [DepthLog2:0]   count
);

   mbd_pkg::result_type       mem_ff [2**DepthLog2];
   logic [DepthLog2-1:0]      wr_ptr_ff;
   logic [DepthLog2-1:0]      wr_ptr_in;
   logic [DepthLog2-1:0]      rd_ptr_ff;
   logic [DepthLog2-1:0]      rd_ptr_in;
   logic [DepthLog2:0]        count_ff;
   logic [DepthLog2:0]        count_in;
   logic                      do_pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (DepthLog2+1)'(push) - (DepthLog2+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/mipmap_box_downsampler_unit.sv */
// ----------------------------------------------------------------------------
// Mipmap box downsampler
// Builds the full mip chain of a square power-of-two RGB image by 2x2 box
// averaging, with one cell per level.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order and each one leaves as a level-0 item,
// followed by every coarser pixel it completes, in increasing level, each
// tagged with level and position and with tlast on the final result of
// each input pixel. An input item passes down the row of cells one result
// at a time, and the next pixel is not taken before its last result. Results
// wait in a queue, and input is taken while that queue has room for a full
// burst of results. A configuration write is taken only while no item is in
// the cells, and a pending write holds off the input.
module mipmap_box_downsampler_unit #(
   parameter int MaxSideLog2 = mbd_pkg::MAX_SIDE_LOG2_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in, green_in, blue_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // level, pos_x, pos_y, red_out, green_out, blue_out
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);

   localparam int CW        = MaxSideLog2;
   localparam int NCELL     = MaxSideLog2 + 1;
   localparam int QLOG2     = $clog2(2 * (MaxSideLog2 + 2));
   localparam int QDEPTH    = 2**QLOG2;
   localparam int QROOM     = QDEPTH - NCELL - 1;

   logic [mbd_pkg::CFG_W-1:0] side_log2_ff;
   logic [mbd_pkg::CFG_W-1:0] side_act;
   logic [CW-1:0]             col_ff;
   logic [CW-1:0]             col_in;
   logic [CW-1:0]             row_ff;
   logic [CW-1:0]             row_in;
   logic [CW-1:0]             side_mask;
   logic                      req_acc;
   logic                      csr_acc;
   mbd_pkg::pixel_type        src_pix;

   logic                      c_in_valid [NCELL];
   logic [CW-1:0]             c_in_x     [NCELL];
   logic [CW-1:0]             c_in_y     [NCELL];
   mbd_pkg::pixel_type        c_in_pix   [NCELL];
   mbd_pkg::cell_flags_type   c_flags    [NCELL];
   logic [CW-1:0]             c_res_x    [NCELL];
   logic [CW-1:0]             c_res_y    [NCELL];
   mbd_pkg::pixel_type        c_res_pix  [NCELL];
   logic                      c_nx_valid [NCELL];
   logic [CW-1:0]             c_nx_x     [NCELL];
   logic [CW-1:0]             c_nx_y     [NCELL];
   mbd_pkg::pixel_type        c_nx_pix   [NCELL];
   logic [NCELL-1:0]          cell_valid;

   logic                      busy;
   logic                      term;
   mbd_pkg::result_type       res;
   logic [QLOG2:0]            q_count;
   logic                      q_valid;
   mbd_pkg::result_type       q_data;

   assign csr_ready = !busy;
   assign csr_acc   = csr_valid && csr_ready;
   assign req_acc   = req_tvalid && req_tready;

   always_comb begin
      side_act = side_log2_ff;
      if (side_log2_ff == '0) begin
         side_act = mbd_pkg::CFG_W'(1);
      end else if (side_log2_ff > mbd_pkg::CFG_W'(MaxSideLog2)) begin
         side_act = mbd_pkg::CFG_W'(MaxSideLog2);
      end
   end

   assign side_mask = CW'((33'd1 << side_act) - 33'd1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_acc) begin
         col_in = '0;
         row_in = '0;
      end else if (req_acc) begin
         if (col_ff == side_mask) begin
            col_in = '0;
            row_in = (row_ff == side_mask) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_log2_ff <= mbd_pkg::SIDE_LOG2_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         if (csr_acc) begin
            side_log2_ff <= csr_data;
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign src_pix.red   = {req_tdata[7:0],   mbd_pkg::FRAC_W'(0)};
   assign src_pix.green = {req_tdata[15:8],  mbd_pkg::FRAC_W'(0)};
   assign src_pix.blue  = {req_tdata[23:16], mbd_pkg::FRAC_W'(0)};

   genvar gi;
   generate
      for (gi = 0; gi < NCELL; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign c_in_valid[gi] = req_acc;
            assign c_in_x[gi]     = col_ff;
            assign c_in_y[gi]     = row_ff;
            assign c_in_pix[gi]   = src_pix;
         end else begin : g_link
            assign c_in_valid[gi] = c_nx_valid[gi-1];
            assign c_in_x[gi]     = c_nx_x[gi-1];
            assign c_in_y[gi]     = c_nx_y[gi-1];
            assign c_in_pix[gi]   = c_nx_pix[gi-1];
         end

         mbd_cell #(
            .MaxLog2 (MaxSideLog2),
            .Level   (gi)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .side_log2  (side_act),
            .in_valid   (c_in_valid[gi]),
            .in_x       (c_in_x[gi]),
            .in_y       (c_in_y[gi]),
            .in_pix     (c_in_pix[gi]),
            .res_flags  (c_flags[gi]),
            .res_x      (c_res_x[gi]),
            .res_y      (c_res_y[gi]),
            .res_pix    (c_res_pix[gi]),
            .next_valid (c_nx_valid[gi]),
            .next_x     (c_nx_x[gi]),
            .next_y     (c_nx_y[gi]),
            .next_pix   (c_nx_pix[gi])
         );

         assign cell_valid[gi] = c_flags[gi].valid;
      end
   endgenerate

   always_comb begin
      busy = 1'b0;
      term = 1'b0;
      res  = '0;
      for (int i = 0; i < NCELL; i++) begin
         if (c_flags[i].valid) begin
            busy      = 1'b1;
            term      = c_flags[i].last;
            res.last  = c_flags[i].last;
            res.pix   = c_res_pix[i];
            res.pos_y = mbd_pkg::POS_W'(c_res_y[i]);
            res.pos_x = mbd_pkg::POS_W'(c_res_x[i]);
            res.level = mbd_pkg::LEVEL_W'(i);
         end
      end
   end

   assign req_tready = (!busy || term) && !csr_valid &&
                       (q_count <= (QLOG2+1)'(QROOM));

   mbd_fifo #(
      .DepthLog2 (QLOG2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (busy),
      .push_data (res),
      .pop       (rsp_tready),
      .out_valid (q_valid),
      .out_data  (q_data),
      .count     (q_count)
   );

   assign rsp_tvalid = q_valid;
   assign rsp_tlast  = q_data.last;
   assign rsp_tdata  = {q_data.pix.blue, q_data.pix.green, q_data.pix.red,
                        q_data.pos_y, q_data.pos_x, q_data.level};

`ifndef SYNTHESIS
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_valid))
      else $error("More than one cell holds an item.");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= (QLOG2+1)'(QDEPTH))
      else $error("Result queue overflow.");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> cell_valid[0])
      else $error("Accepted item did not enter the first cell.");

   a_busy_pushes: assert property (@(posedge clock) disable iff (reset)
      (busy && !term) |=> busy)
      else $error("Item vanished from the cell row before its last result.");
`endif

endmodule
